FILE: rtl/core/rmsf_pkg.sv
// ----------------------------------------------------------------------------
// rmsf_pkg
// Shared widths, defaults and state encodings of the running median speed
// filter.
// ----------------------------------------------------------------------------
package rmsf_pkg;

  localparam int unsigned DIST_W          = 24;
  localparam int unsigned TIME_W          = 16;
  localparam int unsigned MEDIAN_W        = 24;
  localparam int unsigned WINDOW_LEN_DEF  = 15;
  localparam int unsigned SPEED_WIDTH_DEF = 24;
  localparam int unsigned QUEUE_DEPTH     = 2;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_DIV  = 3'b010,
    FS_PUSH = 3'b100
  } rmsf_front_state_e;

  typedef enum logic [3:0] {
    BS_IDLE = 4'b0001,
    BS_DEL  = 4'b0010,
    BS_INS  = 4'b0100,
    BS_OUT  = 4'b1000
  } rmsf_back_state_e;

endpackage

FILE: rtl/core/rmsf_in_if.sv
// ----------------------------------------------------------------------------
// rmsf_in_if
// Input channel: one track segment word per handshake.
// ----------------------------------------------------------------------------
interface rmsf_in_if import rmsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_cm;
  logic [TIME_W-1:0] time_step_s;
  logic              point_deleted;

  modport source (output valid, output distance_cm, output time_step_s,
                  output point_deleted, input ready);
  modport sink   (input valid, input distance_cm, input time_step_s,
                  input point_deleted, output ready);
endinterface

FILE: rtl/core/rmsf_out_if.sv
// ----------------------------------------------------------------------------
// rmsf_out_if
// Output channel: one median speed word per handshake.
// ----------------------------------------------------------------------------
interface rmsf_out_if import rmsf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MEDIAN_W-1:0] median_speed;

  modport source (output valid, output median_speed, input ready);
  modport sink   (input valid, input median_speed, output ready);
endinterface

FILE: rtl/core/rmsf_front.sv
// ----------------------------------------------------------------------------
// rmsf_front
// Accepts segments and forms the speed with a restoring divider, one
// quotient bit per cycle, then hands speed and deleted flag to the queue.
// ----------------------------------------------------------------------------
module rmsf_front import rmsf_pkg::*; #(
  parameter int unsigned SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rmsf_in_if.sink              in_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output logic [SPEED_WIDTH:0] push_data_o
);

  localparam int unsigned CntW = $clog2(DIST_W);
  localparam logic [32:0] SpdMax = (33'd1 << SPEED_WIDTH) - 33'd1;

  rmsf_front_state_e state_q, state_d;
  logic [DIST_W-1:0] dvd_q, dvd_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] dt_q, dt_d;
  logic              del_q, del_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TIME_W:0]   trial;
  logic              fits;
  logic [32:0]       quo_ext;
  logic [SPEED_WIDTH-1:0] speed;

  assign trial = {rem_q, dvd_q[DIST_W-1]};
  assign fits  = (trial >= {1'b0, dt_q});

  // Quotients beyond the speed range saturate.
  assign quo_ext = 33'(dvd_q);
  assign speed   = (quo_ext > SpdMax) ? SpdMax[SPEED_WIDTH-1:0]
                                      : quo_ext[SPEED_WIDTH-1:0];

  assign in_i.ready   = (state_q == FS_IDLE);
  assign push_valid_o = (state_q == FS_PUSH);
  assign push_data_o  = {del_q, speed};

  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dt_d    = dt_q;
    del_d   = del_q;
    cnt_d   = cnt_q;
    case (state_q)
      FS_IDLE: begin
        if (in_i.valid) begin
          del_d = in_i.point_deleted;
          dt_d  = in_i.time_step_s;
          rem_d = '0;
          cnt_d = CntW'(DIST_W - 1);
          if (in_i.time_step_s == '0) begin
            dvd_d   = '0;
            state_d = FS_PUSH;
          end else begin
            dvd_d   = in_i.distance_cm;
            state_d = FS_DIV;
          end
        end
      end
      FS_DIV: begin
        rem_d = fits ? TIME_W'(trial - {1'b0, dt_q}) : trial[TIME_W-1:0];
        dvd_d = {dvd_q[DIST_W-2:0], fits};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (push_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dt_q  <= dt_d;
    del_q <= del_d;
    cnt_q <= cnt_d;
  end

endmodule

FILE: rtl/core/rmsf_fifo.sv
// ----------------------------------------------------------------------------
// rmsf_fifo
// Short queue between the divider front and the window back.
// ----------------------------------------------------------------------------
module rmsf_fifo import rmsf_pkg::*; #(
  parameter int unsigned WIDTH = SPEED_WIDTH_DEF + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wrap_inc(wr_q);
      end
      if (do_pop) begin
        rd_q <= wrap_inc(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/rmsf_back.sv
// ----------------------------------------------------------------------------
// rmsf_back
// Keeps the speed window in arrival order and a sorted copy of it. Each
// word removes the oldest speed from the sorted copy once the window is full,
// inserts the new one, and reads the median at the middle position.
// ----------------------------------------------------------------------------
module rmsf_back import rmsf_pkg::*; #(
  parameter int unsigned WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int unsigned SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  logic [SPEED_WIDTH:0] pop_data_i,
  rmsf_out_if.source           out_o
);

  localparam int unsigned CW     = $clog2(WINDOW_LEN + 1);
  localparam int unsigned MidIdx = WINDOW_LEN >> 1;

  rmsf_back_state_e state_q, state_d;
  logic [SPEED_WIDTH-1:0] win_q [WINDOW_LEN];
  logic [SPEED_WIDTH-1:0] srt_q [WINDOW_LEN];
  logic [SPEED_WIDTH-1:0] del_arr [WINDOW_LEN];
  logic [SPEED_WIDTH-1:0] ins_arr [WINDOW_LEN];
  logic [SPEED_WIDTH-1:0] spd_q;
  logic                   del_q;
  logic [CW-1:0]          cnt_q;
  logic [CW-1:0]          icnt;
  logic                   full;
  logic                   out_valid_q;
  logic [MEDIAN_W-1:0]    med_q;
  logic [31:0]            med_ext;

  assign full        = (cnt_q == CW'(WINDOW_LEN));
  assign pop_ready_o = (state_q == BS_IDLE) && !out_valid_q;
  assign out_o.valid        = out_valid_q;
  assign out_o.median_speed = med_q;
  assign med_ext     = 32'(srt_q[MidIdx]);

  // Dropping the oldest value: every slot from the first one not below it
  // takes its upper neighbor, which removes exactly one copy.
  always_comb begin
    for (int p = 0; p < WINDOW_LEN - 1; p++) begin
      del_arr[p] = (srt_q[p] < win_q[0]) ? srt_q[p] : srt_q[p + 1];
    end
    del_arr[WINDOW_LEN-1] = srt_q[WINDOW_LEN-1];
  end

  // Insertion into the first icnt sorted slots; slots past icnt are empty.
  assign icnt = full ? CW'(WINDOW_LEN - 1) : cnt_q;

  always_comb begin
    ins_arr[0] = ((icnt == '0) || (srt_q[0] > spd_q)) ? spd_q : srt_q[0];
    for (int p = 1; p < WINDOW_LEN; p++) begin
      if ((CW'(p - 1) < icnt) && (srt_q[p-1] > spd_q)) begin
        ins_arr[p] = srt_q[p-1];
      end else if ((CW'(p) >= icnt) || (srt_q[p] > spd_q)) begin
        ins_arr[p] = spd_q;
      end else begin
        ins_arr[p] = srt_q[p];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE: begin
        if (pop_valid_i && !out_valid_q) begin
          state_d = full ? BS_DEL : BS_INS;
        end
      end
      BS_DEL:  state_d = BS_INS;
      BS_INS:  state_d = BS_OUT;
      BS_OUT:  state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == BS_INS) && !full) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if ((state_q == BS_OUT) && !del_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      spd_q <= pop_data_i[SPEED_WIDTH-1:0];
      del_q <= pop_data_i[SPEED_WIDTH];
    end
    if (state_q == BS_DEL) begin
      srt_q <= del_arr;
    end
    if (state_q == BS_INS) begin
      srt_q <= ins_arr;
      for (int p = 0; p < WINDOW_LEN - 1; p++) begin
        win_q[p] <= win_q[p + 1];
      end
      win_q[WINDOW_LEN-1] <= spd_q;
    end
    if (state_q == BS_OUT) begin
      med_q <= full ? med_ext[MEDIAN_W-1:0] : '0;
    end
  end

endmodule

FILE: rtl/core/running_median_speed_filter_core.sv
// ----------------------------------------------------------------------------
// running_median_speed_filter_core
// An accepted segment passes the divider front, the queue and the window
// back before its median word leaves; deleted segments give no word.
// The 24-step bit-serial divider sets the pace: the front takes no new
// segment until the speed of the last one is handed to the queue.
// A zero time step skips the divider; the window back then sets the pace.
// Reset clears control state and the fill count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module running_median_speed_filter_core import rmsf_pkg::*; #(
  parameter int unsigned WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int unsigned SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmsf_in_if.sink    in_i,
  rmsf_out_if.source out_o
);

  logic                 push_valid, push_ready;
  logic [SPEED_WIDTH:0] push_data;
  logic                 pop_valid, pop_ready;
  logic [SPEED_WIDTH:0] pop_data;

  rmsf_front #(
    .SPEED_WIDTH(SPEED_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  rmsf_fifo #(
    .WIDTH(SPEED_WIDTH + 1)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  rmsf_back #(
    .WINDOW_LEN (WINDOW_LEN),
    .SPEED_WIDTH(SPEED_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_o      (out_o)
  );

endmodule

FILE: test/rmsf_median_checker.sv
// ----------------------------------------------------------------------------
// rmsf_median_checker
// Watches the segment and median channels of the running median speed
// filter. It keeps its own speed window, works out the median word that
// every kept segment should give and compares the words as they leave.
// ----------------------------------------------------------------------------
module rmsf_median_checker import rmsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rmsf_in_if   seg_mon,
  rmsf_out_if  med_mon,
  output int   fail_count_o,
  output int   pending_medians_o,
  output int   checked_medians_o
);

  localparam int unsigned WIN = WINDOW_LEN_DEF;
  localparam longint unsigned SPEED_MAX = (64'd1 << SPEED_WIDTH_DEF) - 64'd1;

  logic [SPEED_WIDTH_DEF-1:0] speed_hist [WIN];
  int unsigned                hist_fill;
  logic [MEDIAN_W-1:0]        expected_medians [$];
  int                         mismatches;
  int                         checked;

  initial begin
    mismatches = 0;
    checked    = 0;
  end

  task automatic report_mismatch(input string what, input logic [MEDIAN_W-1:0] got,
                                 input logic [MEDIAN_W-1:0] want);
    $display("MISMATCH at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Truncating quotient in cm/s; a zero time step gives zero speed.
  function automatic logic [SPEED_WIDTH_DEF-1:0] segment_speed(
      input logic [DIST_W-1:0] seg_dist, input logic [TIME_W-1:0] dt);
    longint unsigned q;
    if (dt == '0) return '0;
    q = longint'(seg_dist) / longint'(dt);
    if (q > SPEED_MAX) q = SPEED_MAX;
    return q[SPEED_WIDTH_DEF-1:0];
  endfunction

  function automatic logic [SPEED_WIDTH_DEF-1:0] window_median();
    logic [SPEED_WIDTH_DEF-1:0] sorted [WIN];
    logic [SPEED_WIDTH_DEF-1:0] v;
    int j;
    sorted = speed_hist;
    for (int i = 1; i < WIN; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[WIN >> 1];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SPEED_WIDTH_DEF-1:0] spd;
    logic [MEDIAN_W-1:0]        med;
    if (!rst_ni) begin
      hist_fill = 0;
      expected_medians.delete();
    end else begin
      // A median leaving at this edge can never belong to a segment taken at it.
      if (med_mon.valid && med_mon.ready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch("median word with none expected", med_mon.median_speed, '0);
        end else begin
          med = expected_medians[0];
          expected_medians.delete(0);
          if (med_mon.median_speed !== med)
            report_mismatch("median_speed", med_mon.median_speed, med);
          checked++;
        end
      end
      if (seg_mon.valid && seg_mon.ready) begin
        spd = segment_speed(seg_mon.distance_cm, seg_mon.time_step_s);
        if (hist_fill < WIN) begin
          speed_hist[hist_fill] = spd;
          hist_fill++;
        end else begin
          for (int i = 0; i < WIN - 1; i++) speed_hist[i] = speed_hist[i+1];
          speed_hist[WIN-1] = spd;
        end
        med = (hist_fill >= WIN) ? MEDIAN_W'(window_median()) : '0;
        if (!seg_mon.point_deleted) expected_medians.push_back(med);
      end
    end
    fail_count_o      <= mismatches;
    pending_medians_o <= expected_medians.size();
    checked_medians_o <= checked;
  end

endmodule

FILE: test/tb_running_median_speed_filter_core.sv
// ----------------------------------------------------------------------------
// tb_running_median_speed_filter_core
// Drives track segments into the median speed filter in bursts while the
// median channel stalls on its own pattern. A short directed run covers the
// field extremes, zero time steps, truncation and deleted segments; then
// windows of related speeds with random noise exercise the sorting.
// ----------------------------------------------------------------------------
module tb_running_median_speed_filter_core;
  import rmsf_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_SEGS = 450;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending_medians;
  int   checked_medians;
  int   quiet_cycles = 0;
  int   segs_sent = 0;
  int   segs_deleted = 0;
  int   segs_zero_dt = 0;
  int   burst_left = 0;

  rmsf_in_if  seg_ch ();
  rmsf_out_if med_ch ();

  running_median_speed_filter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (seg_ch),
    .out_o  (med_ch)
  );

  rmsf_median_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .seg_mon           (seg_ch),
    .med_mon           (med_ch),
    .fail_count_o      (fail_count),
    .pending_medians_o (pending_medians),
    .checked_medians_o (checked_medians)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((seg_ch.valid && seg_ch.ready) || (med_ch.valid && med_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Watchdog: %0d cycles without a handshake", QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // The median channel switches between free flow, light and heavy random
  // stalls, and periodic stalls.
  initial begin
    int mode;
    int span;
    int period;
    int open;
    med_ch.ready <= 1'b0;
    forever begin
      mode   = $urandom_range(3, 0);
      span   = $urandom_range(200, 20);
      period = $urandom_range(32, 4);
      open   = $urandom_range(period - 1, 1);
      for (int c = 0; c < span; c++) begin
        @(posedge clk_i);
        case (mode)
          0: begin
            med_ch.ready <= 1'b1;
          end
          1: begin
            med_ch.ready <= ($urandom_range(3, 0) != 0);
          end
          2: begin
            med_ch.ready <= ($urandom_range(3, 0) == 0);
          end
          default: begin
            med_ch.ready <= ((c % period) < open);
          end
        endcase
      end
    end
  end

  // Holds one segment word until it is taken. Between bursts the sender
  // may drop valid for a random gap.
  task automatic send_segment(input logic [DIST_W-1:0] seg_dist,
                              input logic [TIME_W-1:0] dt, input logic del);
    int gap;
    seg_ch.valid         <= 1'b1;
    seg_ch.distance_cm   <= seg_dist;
    seg_ch.time_step_s   <= dt;
    seg_ch.point_deleted <= del;
    @(posedge clk_i);
    while (!seg_ch.ready) @(posedge clk_i);
    segs_sent++;
    if (del) segs_deleted++;
    if (dt == '0) segs_zero_dt++;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(2, 0);
      if (gap != 0) begin
        seg_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(20, 1);
    end else begin
      burst_left--;
    end
  endtask

  // Lowers valid and holds off until every expected median has arrived.
  task automatic drain_medians();
    seg_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_medians != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned     base;
    int unsigned     pick;
    longint unsigned wide;
    logic [DIST_W-1:0] seg_dist;
    logic [TIME_W-1:0] dt;
    logic              del;

    rst_ni               = 1'b0;
    seg_ch.valid         <= 1'b0;
    seg_ch.distance_cm   <= '0;
    seg_ch.time_step_s   <= '0;
    seg_ch.point_deleted <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes and special cases while the window fills, then a
    // few words once the median is live.
    send_segment(24'd0,       16'd0,      1'b0);
    send_segment(24'hFFFFFF,  16'd1,      1'b0);
    send_segment(24'hFFFFFF,  16'hFFFF,   1'b0);
    send_segment(24'd0,       16'hFFFF,   1'b0);
    send_segment(24'hFFFFFF,  16'd0,      1'b0);
    send_segment(24'd1,       16'd2,      1'b0);
    send_segment(24'd7,       16'd2,      1'b0);
    send_segment(24'd123456,  16'd1000,   1'b1);
    for (int k = 1; k <= 7; k++) send_segment(24'(k * 1000), 16'd1, 1'b0);
    send_segment(24'hAAAAAA,  16'h5555,   1'b0);
    send_segment(24'h555555,  16'hAAAA,   1'b1);
    send_segment(24'h555555,  16'h0003,   1'b0);
    send_segment(24'd0,       16'd0,      1'b1);
    for (int k = 0; k < 8; k++) send_segment(24'hFFFFFF, 16'd1, k[0]);
    drain_medians();

    // Random: groups of segments around a common speed, with outliers,
    // zero time steps and fully random words mixed in.
    for (int i = 0; i < RANDOM_SEGS; i++) begin
      if (i % 20 == 0) begin
        base = ($urandom_range(3, 0) == 0) ? $urandom_range(20000, 0)
                                           : $urandom_range(2000, 0);
      end
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        dt   = TIME_W'($urandom_range(60, 1));
        wide = longint'(dt) * (base + $urandom_range(base / 2 + 1, 0));
        if (wide > 64'hFFFFFF) wide = 64'hFFFFFF;
        seg_dist = wide[DIST_W-1:0];
      end else if (pick < 80) begin
        dt       = '0;
        seg_dist = DIST_W'($urandom);
      end else if (pick < 90) begin
        dt       = TIME_W'($urandom);
        seg_dist = DIST_W'($urandom);
      end else begin
        dt       = TIME_W'($urandom_range(3, 1));
        seg_dist = DIST_W'($urandom) | 24'h800000;
      end
      del = ($urandom_range(4, 0) == 0);
      send_segment(seg_dist, dt, del);
      if (i == RANDOM_SEGS / 2) drain_medians();
    end
    drain_medians();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d segments: %0d deleted, %0d with a zero time step.",
             segs_sent, segs_deleted, segs_zero_dt);
    $display("Checked %0d median words across burst and stall patterns.", checked_medians);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
